@@ src/vfdfg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VFD command frame generator package
// Shared widths, codes, byte constants and the controller/datapath interface.
// ----------------------------------------------------------------------------
package vfdfg_pkg;

   localparam int GLYPH_SLOTS_DEF   = 8;
   localparam int MAX_POSITIONS_DEF = 16;
   localparam int GLYPH_COLUMNS     = 5;

   localparam int BYTE_W     = 8;
   localparam int BITMAP_W   = GLYPH_COLUMNS * BYTE_W;
   localparam int COL_CNT_W  = $clog2(GLYPH_COLUMNS);
   localparam int CMD_W      = 4;
   localparam int ROW_W      = 2;
   localparam int COL_W      = 4;
   localparam int ROWS_W     = 3;
   localparam int COLS_W     = 5;
   localparam int KIND_W     = 2;
   localparam int STAT_W     = 2;
   localparam int STR_CNT_W  = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CMD_W-1:0] CMD_INIT      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_BRIGHT    = 4'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd2;
   localparam logic [CMD_W-1:0] CMD_CHAR      = 4'd3;
   localparam logic [CMD_W-1:0] CMD_STR_OPEN  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_STR_CHAR  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_STR_CLOSE = 4'd6;
   localparam logic [CMD_W-1:0] CMD_ADD_GLYPH = 4'd7;
   localparam logic [CMD_W-1:0] CMD_GLYPH     = 4'd8;

   localparam logic [KIND_W-1:0] KIND_BYTE         = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BYTE_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE      = 2'd2;
   localparam logic [KIND_W-1:0] KIND_STATUS       = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [STAT_W-1:0] STAT_REJECTED  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_COLS = 1'b1;

   localparam logic [ROWS_W-1:0] ROWS_RESET = 3'd1;
   localparam logic [COLS_W-1:0] COLS_RESET = 5'd8;

   localparam logic [BYTE_W-1:0] BYTE_DIGIT_COUNT = 8'hE0;
   localparam logic [BYTE_W-1:0] BYTE_BRIGHTNESS  = 8'hE4;
   localparam logic [BYTE_W-1:0] BYTE_REFRESH     = 8'hE8;
   localparam logic [BYTE_W-1:0] BYTE_POS_BASE    = 8'h20;
   localparam logic [BYTE_W-1:0] BYTE_SPACE       = 8'h20;
   localparam logic [BYTE_W-1:0] BYTE_CGRAM_BASE  = 8'h40;
   localparam logic [BYTE_W-1:0] BYTE_CHAR_OFFSET = 8'h30;

   typedef enum logic [3:0] {
      SRC_ZERO      = 4'd0,
      SRC_E0        = 4'd1,
      SRC_POS_MAX   = 4'd2,
      SRC_E4        = 4'd3,
      SRC_LEVEL     = 4'd4,
      SRC_CLR_ADDR  = 4'd5,
      SRC_SPACE     = 4'd6,
      SRC_E8        = 4'd7,
      SRC_POS_ADDR  = 4'd8,
      SRC_CHAR_CODE = 4'd9,
      SRC_CHAR_RAW  = 4'd10,
      SRC_CG_ADDR   = 4'd11,
      SRC_CG_COL    = 4'd12,
      SRC_CG_INDEX  = 4'd13
   } src_type;

   typedef struct packed {
      logic                load;
      logic                emit;
      src_type             src;
      logic [KIND_W-1:0]   kind;
      logic [STAT_W-1:0]   status;
      logic                last;
      logic                clr_next;
      logic                col_next;
      logic                srch_next;
      logic                str_open;
      logic                str_char;
      logic                str_end;
      logic                str_close;
      logic                glyph_store;
   } ctl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             str_active;
      logic             str_room;
      logic             chr_zero;
      logic             glyph_full;
      logic             no_positions;
      logic             clr_last;
      logic             col_last;
      logic             srch_hit;
      logic             srch_miss;
      logic             out_free;
   } dp_sts_type;

endpackage

@@ src/vfdfg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VFD frame generator controller
// Decodes the captured request and steps through the word sequence it needs.
// ----------------------------------------------------------------------------
module vfdfg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  vfdfg_pkg::dp_sts_type  sts,
   output vfdfg_pkg::ctl_cmd_type cmd
);

   typedef enum logic [18:0] {
      ST_IDLE      = 19'h00001,
      ST_DECODE    = 19'h00002,
      ST_SEARCH    = 19'h00004,
      ST_INIT_E0   = 19'h00008,
      ST_INIT_CNT  = 19'h00010,
      ST_BRI_CMD   = 19'h00020,
      ST_BRI_LVL   = 19'h00040,
      ST_CLR_ADDR  = 19'h00080,
      ST_CLR_DATA  = 19'h00100,
      ST_REFRESH   = 19'h00200,
      ST_POS_ADDR  = 19'h00400,
      ST_CHAR_DATA = 19'h00800,
      ST_STR_CHAR  = 19'h01000,
      ST_RELEASE   = 19'h02000,
      ST_STATUS    = 19'h04000,
      ST_CG_ADDR   = 19'h08000,
      ST_CG_COL    = 19'h10000,
      ST_CG_POS    = 19'h20000,
      ST_CG_IDX    = 19'h40000
   } state_type;

   state_type                        state_ff, state_in;
   logic [vfdfg_pkg::STAT_W-1:0]     status_ff, status_in;
   logic                             busy;

   assign req_stall = (state_ff != ST_IDLE);
   assign busy = sts.str_active &&
                 ((sts.command <= vfdfg_pkg::CMD_STR_OPEN) ||
                  (sts.command == vfdfg_pkg::CMD_GLYPH));

   always_comb begin
      state_in        = state_ff;
      status_in       = status_ff;
      cmd             = '0;
      cmd.src         = vfdfg_pkg::SRC_ZERO;
      cmd.kind        = vfdfg_pkg::KIND_BYTE;
      cmd.status      = vfdfg_pkg::STAT_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (busy) begin
               status_in = vfdfg_pkg::STAT_REJECTED;
               state_in  = ST_STATUS;
            end else begin
               unique case (sts.command)
                  vfdfg_pkg::CMD_INIT:   state_in = ST_INIT_E0;
                  vfdfg_pkg::CMD_BRIGHT: state_in = ST_BRI_CMD;
                  vfdfg_pkg::CMD_CLEAR:  state_in = sts.no_positions ? ST_IDLE : ST_CLR_ADDR;
                  vfdfg_pkg::CMD_CHAR:   state_in = ST_POS_ADDR;
                  vfdfg_pkg::CMD_STR_OPEN: begin
                     cmd.str_open = 1'b1;
                     state_in     = ST_POS_ADDR;
                  end
                  vfdfg_pkg::CMD_STR_CHAR: begin
                     if (!sts.str_active) begin
                        status_in = vfdfg_pkg::STAT_REJECTED;
                        state_in  = ST_STATUS;
                     end else if (sts.str_room && sts.chr_zero) begin
                        cmd.str_end = 1'b1;
                        state_in    = ST_IDLE;
                     end else if (sts.str_room) begin
                        cmd.str_char = 1'b1;
                        state_in     = ST_STR_CHAR;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  vfdfg_pkg::CMD_STR_CLOSE: begin
                     if (!sts.str_active) begin
                        status_in = vfdfg_pkg::STAT_REJECTED;
                        state_in  = ST_STATUS;
                     end else begin
                        cmd.str_close = 1'b1;
                        state_in      = ST_RELEASE;
                     end
                  end
                  vfdfg_pkg::CMD_ADD_GLYPH: begin
                     if (sts.glyph_full) begin
                        status_in = vfdfg_pkg::STAT_FULL;
                     end else begin
                        cmd.glyph_store = 1'b1;
                        status_in       = vfdfg_pkg::STAT_OK;
                     end
                     state_in = ST_STATUS;
                  end
                  vfdfg_pkg::CMD_GLYPH:  state_in = ST_SEARCH;
                  default: begin
                     status_in = vfdfg_pkg::STAT_REJECTED;
                     state_in  = ST_STATUS;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (sts.srch_hit) begin
               state_in = ST_CG_ADDR;
            end else if (sts.srch_miss) begin
               status_in = vfdfg_pkg::STAT_NOT_FOUND;
               state_in  = ST_STATUS;
            end else begin
               cmd.srch_next = 1'b1;
            end
         end
         ST_INIT_E0: begin
            cmd.src = vfdfg_pkg::SRC_E0;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_INIT_CNT;
            end
         end
         ST_INIT_CNT: begin
            cmd.src  = vfdfg_pkg::SRC_POS_MAX;
            cmd.kind = vfdfg_pkg::KIND_BYTE_RELEASE;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_BRI_CMD;
            end
         end
         ST_BRI_CMD: begin
            cmd.src = vfdfg_pkg::SRC_E4;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_BRI_LVL;
            end
         end
         ST_BRI_LVL: begin
            cmd.src  = vfdfg_pkg::SRC_LEVEL;
            cmd.kind = vfdfg_pkg::KIND_BYTE_RELEASE;
            cmd.last = (sts.command == vfdfg_pkg::CMD_BRIGHT);
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.command == vfdfg_pkg::CMD_BRIGHT) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = sts.no_positions ? ST_REFRESH : ST_CLR_ADDR;
               end
            end
         end
         ST_CLR_ADDR: begin
            cmd.src = vfdfg_pkg::SRC_CLR_ADDR;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_CLR_DATA;
            end
         end
         ST_CLR_DATA: begin
            cmd.src  = vfdfg_pkg::SRC_SPACE;
            cmd.kind = vfdfg_pkg::KIND_BYTE_RELEASE;
            cmd.last = (sts.command == vfdfg_pkg::CMD_CLEAR) && sts.clr_last;
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.clr_next = 1'b1;
               if (!sts.clr_last) begin
                  state_in = ST_CLR_ADDR;
               end else if (sts.command == vfdfg_pkg::CMD_CLEAR) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_REFRESH;
               end
            end
         end
         ST_REFRESH: begin
            cmd.src  = vfdfg_pkg::SRC_E8;
            cmd.kind = vfdfg_pkg::KIND_BYTE_RELEASE;
            cmd.last = 1'b1;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_POS_ADDR: begin
            cmd.src  = vfdfg_pkg::SRC_POS_ADDR;
            cmd.last = (sts.command == vfdfg_pkg::CMD_STR_OPEN);
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = (sts.command == vfdfg_pkg::CMD_STR_OPEN) ? ST_IDLE : ST_CHAR_DATA;
            end
         end
         ST_CHAR_DATA: begin
            cmd.src  = vfdfg_pkg::SRC_CHAR_CODE;
            cmd.kind = vfdfg_pkg::KIND_BYTE_RELEASE;
            cmd.last = 1'b1;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_STR_CHAR: begin
            cmd.src  = vfdfg_pkg::SRC_CHAR_RAW;
            cmd.last = 1'b1;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RELEASE: begin
            cmd.kind = vfdfg_pkg::KIND_RELEASE;
            cmd.last = 1'b1;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_STATUS: begin
            cmd.kind   = vfdfg_pkg::KIND_STATUS;
            cmd.status = status_ff;
            cmd.last   = 1'b1;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CG_ADDR: begin
            cmd.src = vfdfg_pkg::SRC_CG_ADDR;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_CG_COL;
            end
         end
         ST_CG_COL: begin
            cmd.src  = vfdfg_pkg::SRC_CG_COL;
            cmd.kind = sts.col_last ? vfdfg_pkg::KIND_BYTE_RELEASE : vfdfg_pkg::KIND_BYTE;
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.col_next = 1'b1;
               state_in     = sts.col_last ? ST_CG_POS : ST_CG_COL;
            end
         end
         ST_CG_POS: begin
            cmd.src = vfdfg_pkg::SRC_POS_ADDR;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_CG_IDX;
            end
         end
         ST_CG_IDX: begin
            cmd.src  = vfdfg_pkg::SRC_CG_INDEX;
            cmd.kind = vfdfg_pkg::KIND_BYTE_RELEASE;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_REFRESH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= vfdfg_pkg::STAT_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

@@ src/vfdfg_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VFD frame generator datapath
// Request capture, display geometry, string and glyph state, output word.
// ----------------------------------------------------------------------------
module vfdfg_dpath #(
   parameter int GLYPH_SLOTS   = vfdfg_pkg::GLYPH_SLOTS_DEF,
   parameter int MAX_POSITIONS = vfdfg_pkg::MAX_POSITIONS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [vfdfg_pkg::CMD_W-1:0]          req_command,
   input  logic [vfdfg_pkg::ROW_W-1:0]          req_row,
   input  logic [vfdfg_pkg::COL_W-1:0]          req_col,
   input  logic [vfdfg_pkg::BYTE_W-1:0]         req_character,
   input  logic [vfdfg_pkg::BYTE_W-1:0]         req_level,
   input  logic [vfdfg_pkg::BITMAP_W-1:0]       req_bitmap,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [vfdfg_pkg::BYTE_W-1:0]         rsp_data_byte,
   output logic [vfdfg_pkg::KIND_W-1:0]         rsp_kind,
   output logic [vfdfg_pkg::STAT_W-1:0]         rsp_status,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [vfdfg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vfdfg_pkg::CSR_DATA_W-1:0]     csr_data,
   input  vfdfg_pkg::ctl_cmd_type               cmd,
   output vfdfg_pkg::dp_sts_type                sts
);

   localparam int IDX_W  = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
   localparam int CNT_W  = $clog2(GLYPH_SLOTS + 1);
   localparam int PCNT_W = $clog2(MAX_POSITIONS + 1);

   localparam int BW  = vfdfg_pkg::BYTE_W;
   localparam int SW  = vfdfg_pkg::STR_CNT_W;
   localparam int CCW = vfdfg_pkg::COL_CNT_W;

   logic [vfdfg_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [vfdfg_pkg::ROW_W-1:0]       row_ff, row_in;
   logic [vfdfg_pkg::COL_W-1:0]       col_ff, col_in;
   logic [BW-1:0]                     chr_ff, chr_in;
   logic [BW-1:0]                     level_ff, level_in;
   logic [vfdfg_pkg::BITMAP_W-1:0]    bitmap_ff, bitmap_in;

   logic [vfdfg_pkg::ROWS_W-1:0]      rows_ff, rows_in;
   logic [vfdfg_pkg::COLS_W-1:0]      cols_ff, cols_in;

   logic [BW-1:0]                     glyph_sym_ff [GLYPH_SLOTS];
   logic [vfdfg_pkg::BITMAP_W-1:0]    glyph_col_ff [GLYPH_SLOTS];
   logic [CNT_W-1:0]                  glyph_count_ff, glyph_count_in;

   logic                              str_active_ff, str_active_in;
   logic                              str_ended_ff, str_ended_in;
   logic [SW-1:0]                     str_sent_ff, str_sent_in;
   logic [SW-1:0]                     str_limit_ff, str_limit_in;

   logic [PCNT_W-1:0]                 clr_idx_ff, clr_idx_in;
   logic [CCW-1:0]                    col_cnt_ff, col_cnt_in;
   logic [CNT_W-1:0]                  srch_idx_ff, srch_idx_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]                     rsp_byte_ff, rsp_byte_in;
   logic [vfdfg_pkg::KIND_W-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [vfdfg_pkg::STAT_W-1:0]      rsp_status_ff, rsp_status_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic [BW-1:0]                     size_prod;
   logic [PCNT_W-1:0]                 pos_count;
   logic [BW-1:0]                     position;
   logic [vfdfg_pkg::BITMAP_W-1:0]    cg_word;
   logic [BW-1:0]                     cg_byte;
   logic [SW-1:0]                     open_limit;
   logic                              srch_miss;
   logic [BW-1:0]                     out_byte;

   assign csr_ready = 1'b1;

   assign size_prod = BW'(rows_ff) * BW'(cols_ff);
   assign pos_count = (size_prod > BW'(MAX_POSITIONS)) ? PCNT_W'(MAX_POSITIONS)
                                                       : PCNT_W'(size_prod);
   assign position  = BW'(row_ff) * BW'(cols_ff) + BW'(col_ff);
   assign open_limit = (SW'(col_ff) < cols_ff) ? (cols_ff - SW'(col_ff)) : '0;

   assign srch_miss = (srch_idx_ff >= glyph_count_ff);
   assign cg_word   = glyph_col_ff[srch_idx_ff[IDX_W-1:0]];
   assign cg_byte   = cg_word[{col_cnt_ff, 3'b000} +: BW];

   always_comb begin
      sts              = '0;
      sts.command      = cmd_ff;
      sts.str_active   = str_active_ff;
      sts.str_room     = !str_ended_ff && (str_sent_ff < str_limit_ff);
      sts.chr_zero     = (chr_ff == '0);
      sts.glyph_full   = (glyph_count_ff >= CNT_W'(GLYPH_SLOTS));
      sts.no_positions = (pos_count == '0);
      sts.clr_last     = ((clr_idx_ff + PCNT_W'(1)) == pos_count);
      sts.col_last     = (col_cnt_ff == CCW'(vfdfg_pkg::GLYPH_COLUMNS - 1));
      sts.srch_miss    = srch_miss;
      sts.srch_hit     = !srch_miss && (glyph_sym_ff[srch_idx_ff[IDX_W-1:0]] == chr_ff);
      sts.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      unique case (cmd.src)
         vfdfg_pkg::SRC_ZERO:      out_byte = '0;
         vfdfg_pkg::SRC_E0:        out_byte = vfdfg_pkg::BYTE_DIGIT_COUNT;
         vfdfg_pkg::SRC_POS_MAX:   out_byte = BW'(pos_count) - BW'(1);
         vfdfg_pkg::SRC_E4:        out_byte = vfdfg_pkg::BYTE_BRIGHTNESS;
         vfdfg_pkg::SRC_LEVEL:     out_byte = level_ff;
         vfdfg_pkg::SRC_CLR_ADDR:  out_byte = vfdfg_pkg::BYTE_POS_BASE + BW'(clr_idx_ff);
         vfdfg_pkg::SRC_SPACE:     out_byte = vfdfg_pkg::BYTE_SPACE;
         vfdfg_pkg::SRC_E8:        out_byte = vfdfg_pkg::BYTE_REFRESH;
         vfdfg_pkg::SRC_POS_ADDR:  out_byte = vfdfg_pkg::BYTE_POS_BASE + position;
         vfdfg_pkg::SRC_CHAR_CODE: out_byte = chr_ff + vfdfg_pkg::BYTE_CHAR_OFFSET;
         vfdfg_pkg::SRC_CHAR_RAW:  out_byte = chr_ff;
         vfdfg_pkg::SRC_CG_ADDR:   out_byte = vfdfg_pkg::BYTE_CGRAM_BASE + BW'(srch_idx_ff);
         vfdfg_pkg::SRC_CG_COL:    out_byte = cg_byte;
         vfdfg_pkg::SRC_CG_INDEX:  out_byte = BW'(srch_idx_ff);
         default:                  out_byte = '0;
      endcase
   end

   always_comb begin
      cmd_in    = cmd.load ? req_command   : cmd_ff;
      row_in    = cmd.load ? req_row       : row_ff;
      col_in    = cmd.load ? req_col       : col_ff;
      chr_in    = cmd.load ? req_character : chr_ff;
      level_in  = cmd.load ? req_level     : level_ff;
      bitmap_in = cmd.load ? req_bitmap    : bitmap_ff;

      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_valid) begin
         unique case (csr_index)
            vfdfg_pkg::CSR_DISPLAY_ROWS: rows_in = csr_data[vfdfg_pkg::ROWS_W-1:0];
            vfdfg_pkg::CSR_DISPLAY_COLS: cols_in = csr_data[vfdfg_pkg::COLS_W-1:0];
            default: ;
         endcase
      end

      glyph_count_in = cmd.glyph_store ? glyph_count_ff + CNT_W'(1) : glyph_count_ff;

      str_active_in = str_active_ff;
      str_ended_in  = str_ended_ff;
      str_sent_in   = str_sent_ff;
      str_limit_in  = str_limit_ff;
      if (cmd.str_open) begin
         str_active_in = 1'b1;
         str_ended_in  = 1'b0;
         str_sent_in   = '0;
         str_limit_in  = open_limit;
      end
      if (cmd.str_char) str_sent_in = str_sent_ff + SW'(1);
      if (cmd.str_end) str_ended_in = 1'b1;
      if (cmd.str_close) str_active_in = 1'b0;

      clr_idx_in  = cmd.load ? '0 : (cmd.clr_next  ? clr_idx_ff  + PCNT_W'(1) : clr_idx_ff);
      col_cnt_in  = cmd.load ? '0 : (cmd.col_next  ? col_cnt_ff  + CCW'(1)    : col_cnt_ff);
      srch_idx_in = cmd.load ? '0 : (cmd.srch_next ? srch_idx_ff + CNT_W'(1)  : srch_idx_ff);

      rsp_valid_in  = cmd.emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_byte_in   = cmd.emit ? out_byte   : rsp_byte_ff;
      rsp_kind_in   = cmd.emit ? cmd.kind   : rsp_kind_ff;
      rsp_status_in = cmd.emit ? cmd.status : rsp_status_ff;
      rsp_last_in   = cmd.emit ? cmd.last   : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.glyph_store) begin
         glyph_sym_ff[glyph_count_ff[IDX_W-1:0]] <= chr_ff;
         glyph_col_ff[glyph_count_ff[IDX_W-1:0]] <= bitmap_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      chr_ff        <= chr_in;
      level_ff      <= level_in;
      bitmap_ff     <= bitmap_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff        <= vfdfg_pkg::ROWS_RESET;
         cols_ff        <= vfdfg_pkg::COLS_RESET;
         glyph_count_ff <= '0;
         str_active_ff  <= 1'b0;
         str_ended_ff   <= 1'b0;
         str_sent_ff    <= '0;
         str_limit_ff   <= '0;
         clr_idx_ff     <= '0;
         col_cnt_ff     <= '0;
         srch_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rows_ff        <= rows_in;
         cols_ff        <= cols_in;
         glyph_count_ff <= glyph_count_in;
         str_active_ff  <= str_active_in;
         str_ended_ff   <= str_ended_in;
         str_sent_ff    <= str_sent_in;
         str_limit_ff   <= str_limit_in;
         clr_idx_ff     <= clr_idx_in;
         col_cnt_ff     <= col_cnt_in;
         srch_idx_ff    <= srch_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_byte_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

@@ src/vfd_command_frame_generator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VFD command frame generator core
// Turns display requests into serial VFD controller byte frames.
// ----------------------------------------------------------------------------
// One request is handled at a time: req_stall is low only while the controller
// is idle, and each result word leaves through a single output register, one
// word per cycle while rsp_stall is low. A request is captured, decoded and
// then emits its words: init sends 5 + 2*P words with P = min(rows*cols,
// MAX_POSITIONS), clear 2*P, and a glyph write searches the glyph table (one
// table entry compared per cycle) before its nine words. Requests that produce
// no word return to idle from decode. The user writes display rows and columns
// through the csr_ port only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module vfd_command_frame_generator_core #(
   parameter int GLYPH_SLOTS   = vfdfg_pkg::GLYPH_SLOTS_DEF,
   parameter int MAX_POSITIONS = vfdfg_pkg::MAX_POSITIONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [vfdfg_pkg::CMD_W-1:0]       req_command,
   input  logic [vfdfg_pkg::ROW_W-1:0]       req_row,
   input  logic [vfdfg_pkg::COL_W-1:0]       req_col,
   input  logic [vfdfg_pkg::BYTE_W-1:0]      req_character,
   input  logic [vfdfg_pkg::BYTE_W-1:0]      req_level,
   input  logic [vfdfg_pkg::BITMAP_W-1:0]    req_bitmap,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [vfdfg_pkg::BYTE_W-1:0]      rsp_data_byte,
   output logic [vfdfg_pkg::KIND_W-1:0]      rsp_kind,
   output logic [vfdfg_pkg::STAT_W-1:0]      rsp_status,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vfdfg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vfdfg_pkg::CSR_DATA_W-1:0]  csr_data
);

   vfdfg_pkg::ctl_cmd_type ctl_cmd;
   vfdfg_pkg::dp_sts_type  dp_sts;

   vfdfg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (dp_sts),
      .cmd       (ctl_cmd)
   );

   vfdfg_dpath #(
      .GLYPH_SLOTS   (GLYPH_SLOTS),
      .MAX_POSITIONS (MAX_POSITIONS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_command   (req_command),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_character (req_character),
      .req_level     (req_level),
      .req_bitmap    (req_bitmap),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data_byte (rsp_data_byte),
      .rsp_kind      (rsp_kind),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .cmd           (ctl_cmd),
      .sts           (dp_sts)
   );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VFD command frame generator testbench
// Drives display requests and display-size writes into the core. An in-bench
// frame predictor builds the expected byte words, which are checked in order
// against every word accepted from the result channel. Both channels idle and
// stall at random. The run covers a directed pass followed by random phases
// with different display sizes, zero-size and oversize settings among them.
// ----------------------------------------------------------------------------
module tb;
   import vfdfg_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASES        = 7;
   localparam int PHASE_WORDS   = 50;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      logic [BYTE_W-1:0]   character;
      logic [BYTE_W-1:0]   level;
      logic [BITMAP_W-1:0] bitmap;
   } display_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [KIND_W-1:0] kind;
      logic [STAT_W-1:0] status;
      logic              last;
   } frame_word_type;

   class frame_scoreboard;
      logic [ROWS_W-1:0]    rows;
      logic [COLS_W-1:0]    cols;
      logic [BYTE_W-1:0]    glyph_sym [GLYPH_SLOTS_DEF];
      logic [BITMAP_W-1:0]  glyph_bmp [GLYPH_SLOTS_DEF];
      int                   glyph_count;
      bit                   str_open;
      bit                   str_done;
      logic [STR_CNT_W-1:0] str_sent;
      logic [STR_CNT_W-1:0] str_limit;
      frame_word_type       frames [$];
      int                   errors;

      function new();
         rows        = ROWS_RESET;
         cols        = COLS_RESET;
         glyph_count = 0;
         str_open    = 1'b0;
         str_done    = 1'b0;
         str_sent    = '0;
         str_limit   = '0;
         errors      = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_DISPLAY_ROWS) begin
            rows = value[ROWS_W-1:0];
         end else begin
            cols = value[COLS_W-1:0];
         end
      endfunction

      function void emit(logic [BYTE_W-1:0] b, logic [KIND_W-1:0] k,
                         logic [STAT_W-1:0] s = STAT_OK);
         frame_word_type w;
         w.data_byte = b;
         w.kind      = k;
         w.status    = s;
         w.last      = 1'b0;
         frames.push_back(w);
      endfunction

      function int position_count();
         int n;
         n = int'(rows) * int'(cols);
         return (n > MAX_POSITIONS_DEF) ? MAX_POSITIONS_DEF : n;
      endfunction

      function logic [BYTE_W-1:0] position_addr(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
         return BYTE_POS_BASE + BYTE_W'(int'(row) * int'(cols) + int'(col));
      endfunction

      function void emit_brightness(logic [BYTE_W-1:0] level);
         emit(BYTE_BRIGHTNESS, KIND_BYTE);
         emit(level, KIND_BYTE_RELEASE);
      endfunction

      function void emit_clear();
         int i;
         for (i = 0; i < position_count(); i++) begin
            emit(BYTE_POS_BASE + BYTE_W'(i), KIND_BYTE);
            emit(BYTE_SPACE, KIND_BYTE_RELEASE);
         end
      endfunction

      // Predict the words for one accepted request; returns how many.
      function int note_request(display_req_type r);
         int             first;
         int             hit;
         int             i;
         int             j;
         frame_word_type w;
         first = frames.size();
         if (str_open && (r.command <= CMD_STR_OPEN || r.command == CMD_GLYPH)) begin
            emit('0, KIND_STATUS, STAT_REJECTED);
         end else begin
            case (r.command)
               CMD_INIT: begin
                  emit(BYTE_DIGIT_COUNT, KIND_BYTE);
                  emit(BYTE_W'(position_count() - 1), KIND_BYTE_RELEASE);
                  emit_brightness(r.level);
                  emit_clear();
                  emit(BYTE_REFRESH, KIND_BYTE_RELEASE);
               end
               CMD_BRIGHT: emit_brightness(r.level);
               CMD_CLEAR: emit_clear();
               CMD_CHAR: begin
                  emit(position_addr(r.row, r.col), KIND_BYTE);
                  emit(r.character + BYTE_CHAR_OFFSET, KIND_BYTE_RELEASE);
               end
               CMD_STR_OPEN: begin
                  emit(position_addr(r.row, r.col), KIND_BYTE);
                  str_open  = 1'b1;
                  str_done  = 1'b0;
                  str_sent  = '0;
                  str_limit = ({1'b0, r.col} < cols) ? STR_CNT_W'(cols - {1'b0, r.col}) : '0;
               end
               CMD_STR_CHAR: begin
                  if (!str_open) begin
                     emit('0, KIND_STATUS, STAT_REJECTED);
                  end else if (!str_done && str_sent < str_limit) begin
                     if (r.character == '0) begin
                        str_done = 1'b1;
                     end else begin
                        emit(r.character, KIND_BYTE);
                        str_sent = str_sent + 1'b1;
                     end
                  end
               end
               CMD_STR_CLOSE: begin
                  if (!str_open) begin
                     emit('0, KIND_STATUS, STAT_REJECTED);
                  end else begin
                     emit('0, KIND_RELEASE);
                     str_open = 1'b0;
                  end
               end
               CMD_ADD_GLYPH: begin
                  if (glyph_count >= GLYPH_SLOTS_DEF) begin
                     emit('0, KIND_STATUS, STAT_FULL);
                  end else begin
                     glyph_sym[glyph_count] = r.character;
                     glyph_bmp[glyph_count] = r.bitmap;
                     glyph_count++;
                     emit('0, KIND_STATUS, STAT_OK);
                  end
               end
               CMD_GLYPH: begin
                  hit = -1;
                  for (i = 0; i < glyph_count && hit < 0; i++) begin
                     if (glyph_sym[i] == r.character) hit = i;
                  end
                  if (hit < 0) begin
                     emit('0, KIND_STATUS, STAT_NOT_FOUND);
                  end else begin
                     emit(BYTE_CGRAM_BASE + BYTE_W'(hit), KIND_BYTE);
                     for (j = 0; j < GLYPH_COLUMNS; j++) begin
                        emit(glyph_bmp[hit][BYTE_W*j +: BYTE_W],
                             (j == GLYPH_COLUMNS - 1) ? KIND_BYTE_RELEASE : KIND_BYTE);
                     end
                     emit(position_addr(r.row, r.col), KIND_BYTE);
                     emit(BYTE_W'(hit), KIND_BYTE_RELEASE);
                     emit(BYTE_REFRESH, KIND_BYTE_RELEASE);
                  end
               end
               default: emit('0, KIND_STATUS, STAT_REJECTED);
            endcase
         end
         if (frames.size() > first) begin
            w = frames.pop_back();
            w.last = 1'b1;
            frames.push_back(w);
         end
         return frames.size() - first;
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_word(frame_word_type got);
         frame_word_type want;
         if (frames.size() == 0) begin
            report($sformatf("unexpected word byte=%02h kind=%0d status=%0d last=%0b",
                             got.data_byte, got.kind, got.status, got.last));
            return;
         end
         want = frames.pop_front();
         if (got.data_byte !== want.data_byte || got.kind !== want.kind ||
             got.status !== want.status || got.last !== want.last) begin
            report($sformatf("word byte=%02h kind=%0d status=%0d last=%0b, want %02h/%0d/%0d/%0b",
                             got.data_byte, got.kind, got.status, got.last,
                             want.data_byte, want.kind, want.status, want.last));
         end
      endtask
   endclass

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_command   = '0;
   logic [ROW_W-1:0]      req_row       = '0;
   logic [COL_W-1:0]      req_col       = '0;
   logic [BYTE_W-1:0]     req_character = '0;
   logic [BYTE_W-1:0]     req_level     = '0;
   logic [BITMAP_W-1:0]   req_bitmap    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [BYTE_W-1:0]     rsp_data_byte;
   logic [KIND_W-1:0]     rsp_kind;
   logic [STAT_W-1:0]     rsp_status;
   logic                  rsp_last;
   logic                  csr_valid     = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index     = '0;
   logic [CSR_DATA_W-1:0] csr_data      = '0;

   frame_scoreboard sb;
   int              cycle_count = 0;
   int              stall_left  = 0;
   int              stall_draw;
   bit              rsp_calm    = 1'b0;
   bit              req_calm    = 1'b0;
   int              directed_words;
   int              phase_words;
   int              phase_rows [PHASES] = '{4, 0, 7, 1, 2, 3, 4};
   int              phase_cols [PHASES] = '{16, 16, 31, 1, 0, 5, 4};
   bit              phase_wcols [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

   vfd_command_frame_generator_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_character (req_character),
      .req_level     (req_level),
      .req_bitmap    (req_bitmap),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data_byte (rsp_data_byte),
      .rsp_kind      (rsp_kind),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Result side: raise stall at random, mostly while a word is offered, and not in calm spells.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if ($urandom_range(0, 63) == 0) rsp_calm <= ~rsp_calm;
         if (rsp_stall) begin
            if (stall_left <= 1) rsp_stall <= 1'b0;
            else stall_left <= stall_left - 1;
         end else if (!rsp_calm && (rsp_valid || $urandom_range(0, 7) == 0)) begin
            stall_draw = $urandom_range(0, 11);
            if (stall_draw != 0) begin
               rsp_stall  <= 1'b1;
               stall_left <= stall_draw;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_word('{rsp_data_byte, rsp_kind, rsp_status, rsp_last});
      end
   end

   function automatic display_req_type make_req(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                                                logic [COL_W-1:0] col, logic [BYTE_W-1:0] chr,
                                                logic [BYTE_W-1:0] level,
                                                logic [BITMAP_W-1:0] bitmap);
      display_req_type r;
      r.command   = cmd;
      r.row       = row;
      r.col       = col;
      r.character = chr;
      r.level     = level;
      r.bitmap    = bitmap;
      return r;
   endfunction

   function automatic display_req_type random_req();
      return make_req(CMD_W'($urandom_range(0, 15)), ROW_W'($urandom_range(0, 3)),
                      COL_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)),
                      BYTE_W'($urandom_range(0, 255)), BITMAP_W'({$urandom(), $urandom()}));
   endfunction

   task automatic send_request(input display_req_type r, inout int produced);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= r.command;
      req_row       <= r.row;
      req_col       <= r.col;
      req_character <= r.character;
      req_level     <= r.level;
      req_bitmap    <= r.bitmap;
      do @(posedge clock); while (req_stall);
      void'(sb.note_request(r));
      produced++;
   endtask

   task automatic program_display(input bit wr_rows, input logic [ROWS_W-1:0] rows,
                                  input bit wr_cols, input logic [COLS_W-1:0] cols);
      if (wr_rows) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_DISPLAY_ROWS;
         csr_data  <= CSR_DATA_W'(rows);
         do @(posedge clock); while (!csr_ready);
         sb.write_register(CSR_DISPLAY_ROWS, CSR_DATA_W'(rows));
      end
      if (wr_cols) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_DISPLAY_COLS;
         csr_data  <= CSR_DATA_W'(cols);
         do @(posedge clock); while (!csr_ready);
         sb.write_register(CSR_DISPLAY_COLS, CSR_DATA_W'(cols));
      end
      csr_valid <= 1'b0;
   endtask

   task automatic drain_frames();
      req_valid <= 1'b0;
      while (sb.frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random sequence: mostly well-formed strings and single requests, some noise.
   task automatic run_sequence(inout int produced);
      display_req_type r;
      int              pick;
      int              max_col;
      int              n;
      int              k;
      int              stop_at;
      int              busy_at;
      req_calm = ($urandom_range(0, 4) == 0);
      pick     = $urandom_range(0, 99);
      r        = random_req();
      max_col  = (sb.cols == 0 || sb.cols > 16) ? 15 : sb.cols - 1;
      if (pick < 30) begin
         r.command = CMD_STR_OPEN;
         if ($urandom_range(0, 3) != 0) r.col = COL_W'($urandom_range(0, max_col));
         send_request(r, produced);
         n       = $urandom_range(0, 18);
         stop_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : -1;
         busy_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : -1;
         for (k = 0; k < n; k++) begin
            if (k == busy_at) begin
               r = random_req();
               case ($urandom_range(0, 2))
                  0: r.command = CMD_W'($urandom_range(CMD_INIT, CMD_STR_OPEN));
                  1: r.command = CMD_GLYPH;
                  default: r.command = CMD_ADD_GLYPH;
               endcase
               send_request(r, produced);
            end
            r           = random_req();
            r.command   = CMD_STR_CHAR;
            r.character = (k == stop_at) ? '0 : BYTE_W'($urandom_range(1, 255));
            send_request(r, produced);
         end
         r = random_req();
         r.command = CMD_STR_CLOSE;
         send_request(r, produced);
      end else begin
         if (pick < 45) begin
            r.command = CMD_CHAR;
         end else if (pick < 55) begin
            r.command = CMD_ADD_GLYPH;
            if ($urandom_range(0, 1) == 0) r.character = BYTE_W'($urandom_range(0, 7));
         end else if (pick < 70) begin
            r.command = CMD_GLYPH;
            if (sb.glyph_count > 0 && $urandom_range(0, 3) != 0) begin
               r.character = sb.glyph_sym[$urandom_range(0, sb.glyph_count - 1)];
            end
         end else if (pick < 78) begin
            r.command = CMD_BRIGHT;
         end else if (pick < 84) begin
            r.command = CMD_CLEAR;
         end else if (pick < 88) begin
            r.command = CMD_INIT;
         end
         send_request(r, produced);
      end
   endtask

   initial begin
      int p;
      sb = new();
      directed_words = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_request(make_req(CMD_INIT, 0, 0, 0, 8'h00, '0), directed_words);
      send_request(make_req(CMD_INIT, 3, 15, 8'hFF, 8'hFF, '1), directed_words);
      send_request(make_req(CMD_BRIGHT, 0, 0, 0, 8'hA5, '0), directed_words);
      send_request(make_req(CMD_CLEAR, 0, 0, 0, 0, '0), directed_words);
      send_request(make_req(CMD_CHAR, 3, 15, 8'hFF, 0, '0), directed_words);
      send_request(make_req(CMD_CHAR, 0, 0, 8'h00, 0, '0), directed_words);
      send_request(make_req(CMD_STR_CHAR, 0, 0, 8'h41, 0, '0), directed_words);
      send_request(make_req(CMD_STR_CLOSE, 0, 0, 0, 0, '0), directed_words);
      send_request(make_req(CMD_STR_OPEN, 1, 5, 0, 0, '0), directed_words);
      send_request(make_req(CMD_STR_CHAR, 0, 0, 8'h41, 0, '0), directed_words);
      send_request(make_req(CMD_ADD_GLYPH, 0, 0, 8'h00, 0, '1), directed_words);
      send_request(make_req(CMD_INIT, 0, 0, 0, 8'h10, '0), directed_words);
      send_request(make_req(CMD_GLYPH, 0, 0, 8'h00, 0, '0), directed_words);
      send_request(make_req(CMD_STR_CHAR, 0, 0, 8'h42, 0, '0), directed_words);
      send_request(make_req(CMD_STR_CHAR, 0, 0, 8'h43, 0, '0), directed_words);
      send_request(make_req(CMD_STR_CHAR, 0, 0, 8'h44, 0, '0), directed_words);
      send_request(make_req(CMD_STR_CLOSE, 0, 0, 0, 0, '0), directed_words);
      send_request(make_req(CMD_STR_OPEN, 0, 15, 0, 0, '0), directed_words);
      send_request(make_req(CMD_STR_CHAR, 0, 0, 8'h78, 0, '0), directed_words);
      send_request(make_req(CMD_STR_CLOSE, 0, 0, 0, 0, '0), directed_words);
      send_request(make_req(CMD_STR_OPEN, 2, 0, 0, 0, '0), directed_words);
      send_request(make_req(CMD_STR_CHAR, 0, 0, 8'h00, 0, '0), directed_words);
      send_request(make_req(CMD_STR_CHAR, 0, 0, 8'h51, 0, '0), directed_words);
      send_request(make_req(CMD_STR_CLOSE, 0, 0, 0, 0, '0), directed_words);
      send_request(make_req(CMD_GLYPH, 3, 7, 8'h00, 0, '0), directed_words);
      send_request(make_req(CMD_GLYPH, 1, 2, 8'h77, 0, '0), directed_words);
      send_request(make_req(4'hF, 0, 0, 0, 0, '0), directed_words);
      send_request(make_req(CMD_ADD_GLYPH, 0, 0, 8'hFF, 0, '0), directed_words);
      drain_frames();

      for (p = 0; p < PHASES; p++) begin
         program_display(1'b1, ROWS_W'(phase_rows[p]), phase_wcols[p], COLS_W'(phase_cols[p]));
         phase_words = 0;
         req_calm    = 1'b0;
         send_request(make_req(CMD_INIT, 0, 0, 0, BYTE_W'($urandom_range(0, 255)), '0),
                      phase_words);
         while (phase_words < PHASE_WORDS) run_sequence(phase_words);
         drain_frames();
      end

      if (sb.frames.size() != 0) sb.report("words still expected at end of run");
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
